FILE: rtl/battery_adc_to_voltage_interp_defines.svh
// assertion macros for the battery converter code to voltage block
// no dependencies; included by the modules that carry assertions
`ifndef BATTERY_ADC_TO_VOLTAGE_INTERP_DEFINES_SVH
`define BATTERY_ADC_TO_VOLTAGE_INTERP_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication after a fixed number of cycles
`define ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_AFTER(label, clk, rst, ante, n, cons, msg)
`endif
`endif

FILE: rtl/bavi_pkg.sv
// shared types, codes and the breakpoint table of the converter code to voltage block
// no dependencies
package bavi_pkg;

   localparam int TABLE_ENTRIES_DEF = 35;
   localparam int ADC_BITS_DEF      = 12;

   // breakpoint table, codes descending, voltage falls by one step per entry
   localparam int TAB_LEN    = 35;
   localparam int TAB_CODE_W = 12;
   localparam logic [TAB_CODE_W-1:0] TAB_CODE [TAB_LEN] = '{
      12'h8cc, 12'h8a3, 12'h87a, 12'h851, 12'h828,
      12'h7ff, 12'h7d6, 12'h7ad, 12'h784, 12'h75b,
      12'h732, 12'h709, 12'h6e0, 12'h6b7, 12'h68e,
      12'h666, 12'h63d, 12'h614, 12'h5eb, 12'h5c2,
      12'h599, 12'h570, 12'h547, 12'h51e, 12'h4f5,
      12'h4cc, 12'h4a3, 12'h47a, 12'h451, 12'h428,
      12'h3ff, 12'h3d6, 12'h3ad, 12'h384, 12'h35b
   };

   localparam int VOLT_W     = 10;
   localparam logic [VOLT_W-1:0] TOP_VOLTS = 10'd550;
   localparam int STEP_VOLTS = 10;
   // widths of the widest gap between neighbouring codes, and of ten times it
   localparam int SPAN_W     = 6;
   localparam int NUM_W      = 10;
   localparam int FRAC_W     = 4;
   localparam int FRAC_MAX   = STEP_VOLTS - 1;

   // calibration
   localparam int GAIN_W     = 13;
   localparam int GAIN_MIN   = -3365;
   localparam int GAIN_MAX   = 3750;
   localparam int GAIN_SHIFT = 16;
   localparam int THR_W      = 10;
   localparam logic [THR_W-1:0] FATAL_RESET = 10'd370;

   // control register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = GAIN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH = 1'b1;

   // range status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_INTERP = 2'd0;
   localparam status_type ST_ABOVE  = 2'd1;
   localparam status_type ST_BELOW  = 2'd2;

   // control that travels with each item down the pipeline
   typedef struct packed {
      logic       valid;
      status_type status;
   } ctl_type;

endpackage

FILE: rtl/battery_adc_to_voltage_interp.sv
// battery converter code to voltage, piecewise-linear over a fixed breakpoint table
// throughput: one sample per clock while busy is low; a five-stage pipeline with no stall path
// busy is high during reset and for one cycle after it; the receiver cannot stall
// synchronous reset empties the pipeline and loads gain 0 and threshold 370
// depends on bavi_pkg, bavi_search, bavi_interp, bavi_gain and the defines header
`include "battery_adc_to_voltage_interp_defines.svh"
module battery_adc_to_voltage_interp import bavi_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample transfer
   input  logic                  start,
   output logic                  busy,
   input  logic [ADC_BITS-1:0]   req_adc_code,
   // result transfer
   output logic                  rsp_valid,
   output logic [VOLT_W-1:0]     rsp_voltage_centivolts,
   output logic                  rsp_is_fatal,
   output logic [1:0]            rsp_range_status,
   // register writes
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int N_USED  = (TABLE_ENTRIES < TAB_LEN) ? TABLE_ENTRIES : TAB_LEN;
   localparam int IDX_W   = $clog2(N_USED);
   localparam int CMP_W   = (ADC_BITS > TAB_CODE_W) ? ADC_BITS : TAB_CODE_W;
   localparam int LATENCY = 5;

   logic              busy_ff;
   logic              accept;
   logic [GAIN_W-1:0] gain_ff;
   logic [THR_W-1:0]  thresh_ff;
   ctl_type           s1_ctl, s3_ctl, s5_ctl;
   logic [CMP_W-1:0]  s1_code;
   logic [IDX_W-1:0]  s1_idx;
   logic [VOLT_W-1:0] s3_volts;

   // busy only while coming out of reset
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= '0;
         thresh_ff <= FATAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GAIN:   gain_ff   <= csr_write_data[GAIN_W-1:0];
            CSR_THRESH: thresh_ff <= csr_write_data[THR_W-1:0];
            default:    gain_ff   <= gain_ff;
         endcase
      end
   end

   bavi_search #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADC_BITS      (ADC_BITS)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_code  (req_adc_code),
      .out_ctl  (s1_ctl),
      .out_code (s1_code),
      .out_idx  (s1_idx)
   );

   bavi_interp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADC_BITS      (ADC_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s1_ctl),
      .in_code   (s1_code),
      .in_idx    (s1_idx),
      .out_ctl   (s3_ctl),
      .out_volts (s3_volts)
   );

   bavi_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s3_ctl),
      .in_volts  (s3_volts),
      .gain_raw  (gain_ff),
      .threshold (thresh_ff),
      .out_ctl   (s5_ctl),
      .out_volts (rsp_voltage_centivolts),
      .out_fatal (rsp_is_fatal)
   );

   assign rsp_valid        = s5_ctl.valid;
   assign rsp_range_status = s5_ctl.status;

   // every accepted sample comes out after the pipeline latency
   `ASSERT_AFTER(a_latency, clock, reset, accept, LATENCY, rsp_valid, "transfer lost in pipeline")
   // below-table results are zero volts and always fatal
   `ASSERT_IMPLY(a_below, clock, reset, rsp_valid && rsp_range_status == ST_BELOW, rsp_voltage_centivolts == '0 && rsp_is_fatal, "below-table result wrong")
   // clamped results carry the top voltage with no correction
   `ASSERT_IMPLY(a_above, clock, reset, rsp_valid && rsp_range_status == ST_ABOVE, rsp_voltage_centivolts == TOP_VOLTS, "clamped result not top voltage")

endmodule

FILE: rtl/bavi_search.sv
// stage 1: parallel compare of the sample against every breakpoint, segment select
// depends on bavi_pkg
module bavi_search import bavi_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF,
   localparam int N_USED = (TABLE_ENTRIES < TAB_LEN) ? TABLE_ENTRIES : TAB_LEN,
   localparam int IDX_W  = $clog2(N_USED),
   localparam int CMP_W  = (ADC_BITS > TAB_CODE_W) ? ADC_BITS : TAB_CODE_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [ADC_BITS-1:0] in_code,
   output ctl_type             out_ctl,
   output logic [CMP_W-1:0]    out_code,
   output logic [IDX_W-1:0]    out_idx
);

   logic [CMP_W-1:0] code_ext;
   logic             found;
   ctl_type          ctl_ff, ctl_in;
   logic [CMP_W-1:0] code_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign code_ext = CMP_W'(in_code);

   // first breakpoint at or below the sample, lowest index wins
   always_comb begin
      idx_in = '0;
      found  = 1'b0;
      for (int i = N_USED - 1; i >= 0; i--) begin
         if (CMP_W'(TAB_CODE[i]) <= code_ext) begin
            idx_in = IDX_W'(i);
            found  = 1'b1;
         end
      end
   end

   // range classification
   always_comb begin
      ctl_in.valid = in_valid;
      if (code_ext > CMP_W'(TAB_CODE[0])) begin
         ctl_in.status = ST_ABOVE;
      end else if (found) begin
         ctl_in.status = ST_INTERP;
      end else begin
         ctl_in.status = ST_BELOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.status <= ctl_in.status;
      code_ff       <= code_ext;
      idx_ff        <= idx_in;
   end

   assign out_ctl  = ctl_ff;
   assign out_code = code_ff;
   assign out_idx  = idx_ff;

endmodule

FILE: rtl/bavi_interp.sv
// stages 2 and 3: segment operands from the table, then the fractional step
// depends on bavi_pkg
module bavi_interp import bavi_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF,
   localparam int N_USED = (TABLE_ENTRIES < TAB_LEN) ? TABLE_ENTRIES : TAB_LEN,
   localparam int IDX_W  = $clog2(N_USED),
   localparam int CMP_W  = (ADC_BITS > TAB_CODE_W) ? ADC_BITS : TAB_CODE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           in_ctl,
   input  logic [CMP_W-1:0]  in_code,
   input  logic [IDX_W-1:0]  in_idx,
   output ctl_type           out_ctl,
   output logic [VOLT_W-1:0] out_volts
);

   localparam int MUL_W = SPAN_W + FRAC_W;

   logic [TAB_CODE_W-1:0] lower_code, upper_code;
   logic [IDX_W-1:0]      upper_idx;
   logic [CMP_W-1:0]      diff_full;
   logic [TAB_CODE_W-1:0] span_full;

   ctl_type           ctl2_ff, ctl3_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [VOLT_W-1:0] base_ff, base_in;
   logic [FRAC_W-1:0] frac;
   logic [VOLT_W-1:0] volts_ff, volts_in;

   // segment ends; the top entry is a zero-width segment
   assign upper_idx  = (in_idx == '0) ? in_idx : IDX_W'(in_idx - 1'b1);
   assign lower_code = TAB_CODE[in_idx];
   assign upper_code = TAB_CODE[upper_idx];
   assign diff_full  = in_code - CMP_W'(lower_code);
   assign span_full  = upper_code - lower_code;

   // stage 2 operands: scaled offset into the segment, its width, its base voltage
   always_comb begin
      num_in  = NUM_W'(diff_full[SPAN_W-1:0]) * NUM_W'(STEP_VOLTS);
      span_in = span_full[SPAN_W-1:0];
      base_in = TOP_VOLTS - VOLT_W'(in_idx) * VOLT_W'(STEP_VOLTS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else begin
         ctl2_ff.valid <= in_ctl.valid;
      end
      ctl2_ff.status <= in_ctl.status;
      num_ff         <= num_in;
      span_ff        <= span_in;
      base_ff        <= base_in;
   end

   // quotient below one step: compare against each multiple of the span
   always_comb begin
      frac = '0;
      if (span_ff != '0) begin
         for (int k = 1; k <= FRAC_MAX; k++) begin
            if (MUL_W'(span_ff) * MUL_W'(k) <= MUL_W'(num_ff)) begin
               frac = FRAC_W'(k);
            end
         end
      end
   end

   // stage 3 voltage by range
   always_comb begin
      case (ctl2_ff.status)
         ST_ABOVE:  volts_in = TOP_VOLTS;
         ST_INTERP: volts_in = base_ff + VOLT_W'(frac);
         default:   volts_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff.valid <= 1'b0;
      end else begin
         ctl3_ff.valid <= ctl2_ff.valid;
      end
      ctl3_ff.status <= ctl2_ff.status;
      volts_ff       <= volts_in;
   end

   assign out_ctl   = ctl3_ff;
   assign out_volts = volts_ff;

endmodule

FILE: rtl/bavi_gain.sv
// stages 4 and 5: calibration multiply, truncating scale, clamp and fatal compare
// depends on bavi_pkg
module bavi_gain import bavi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctl_type           in_ctl,
   input  logic [VOLT_W-1:0] in_volts,
   input  logic [GAIN_W-1:0] gain_raw,
   input  logic [THR_W-1:0]  threshold,
   output ctl_type           out_ctl,
   output logic [VOLT_W-1:0] out_volts,
   output logic              out_fatal
);

   localparam int PROD_W = VOLT_W + 1 + GAIN_W;
   localparam int SUM_W  = VOLT_W + 2;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << GAIN_SHIFT) - 1);

   logic signed [GAIN_W-1:0] gain_s, gain_used;
   ctl_type                  ctl4_ff, ctl5_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [VOLT_W-1:0]        volts4_ff;
   logic signed [PROD_W-1:0] biased, shifted;
   logic signed [SUM_W-1:0]  adj, sum;
   logic [VOLT_W-1:0]        volts5_ff, volts5_in;
   logic                     fatal_ff, fatal_in;

   // gain outside the calibrated range counts as zero
   assign gain_s    = $signed(gain_raw);
   assign gain_used = (gain_s < GAIN_MIN || gain_s > GAIN_MAX) ? '0 : gain_s;

   // correction product, only for interpolated items
   always_comb begin
      if (in_ctl.status == ST_INTERP) begin
         prod_in = PROD_W'($signed({1'b0, in_volts})) * PROD_W'(gain_used);
      end else begin
         prod_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff.valid <= 1'b0;
      end else begin
         ctl4_ff.valid <= in_ctl.valid;
      end
      ctl4_ff.status <= in_ctl.status;
      prod_ff        <= prod_in;
      volts4_ff      <= in_volts;
   end

   // scale down with truncation toward zero, add, clamp at zero
   always_comb begin
      biased  = (prod_ff < 0) ? prod_ff + ROUND_BIAS : prod_ff;
      shifted = biased >>> GAIN_SHIFT;
      adj     = shifted[SUM_W-1:0];
      sum     = $signed({2'b00, volts4_ff}) + adj;
      if (sum < 0) begin
         volts5_in = '0;
      end else begin
         volts5_in = sum[VOLT_W-1:0];
      end
      fatal_in = (threshold >= volts5_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff.valid <= 1'b0;
      end else begin
         ctl5_ff.valid <= ctl4_ff.valid;
      end
      ctl5_ff.status <= ctl4_ff.status;
      volts5_ff      <= volts5_in;
      fatal_ff       <= fatal_in;
   end

   assign out_ctl   = ctl5_ff;
   assign out_volts = volts5_ff;
   assign out_fatal = fatal_ff;

endmodule
